FILE: src/lifo_stack_with_min_max_macros.svh
// Assertion macros for the min/max stack.
// Used by files that check their own logic; needs clk and rst_n in scope.
`ifndef LIFO_STACK_WITH_MIN_MAX_MACROS_SVH
`define LIFO_STACK_WITH_MIN_MAX_MACROS_SVH

// same-cycle implication
`define LMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lmm_pkg.sv
// Types and constants for the min/max stack.
// No dependencies.
`timescale 1ns / 1ps
package lmm_pkg;

  localparam int WordW      = 32;
  localparam int StackDepth = 256;
  localparam int DepthW     = $clog2(StackDepth + 1);
  localparam int StatW      = 2;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  typedef struct packed {
    logic              command;
    logic signed [WordW-1:0] value;
  } lmm_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] popped_value;
    logic [StatW-1:0]        status;
    logic [DepthW-1:0]       depth;
    logic signed [WordW-1:0] least_value;
    logic signed [WordW-1:0] greatest_value;
    logic                    stack_empty;
  } lmm_out_t;

  typedef struct packed {
    logic signed [WordW-1:0] min_val;
    logic signed [WordW-1:0] max_val;
  } lmm_ext_t;

endpackage

FILE: src/lmm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lmm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/lifo_stack_with_min_max.sv
// Top level of the bounded LIFO stack with running minimum and maximum.
// Depends on lmm_pkg, lmm_ram and lifo_stack_with_min_max_macros.svh.
//
// Use:
//   Command channel: drive in_data and raise start; the command is taken at
//   a rising edge where start is high and busy is low. in_data.command is
//   push (value is stored) or pop (top word is removed).
//   Result channel: out_strobe is high for exactly one cycle with out_data
//   holding the popped word, status, depth and current least and greatest
//   word. Every command gives one result. The receiver cannot stall; a
//   result not taken in its strobe cycle is lost.
// Timing:
//   The transfer edge launches the memory reads, busy is high for the next
//   cycle while the block combines read data and writes back, and the
//   result strobe follows in the cycle after. The word and min/max
//   memories have registered read data, and no command is taken while
//   busy is high; the next command may be given while the previous result
//   is on the output.
// Reset:
//   rst_n (synchronous, active low) empties the stack and clears busy and
//   out_strobe. Memory contents are not cleared; only entries below the
//   top ever reach a result.
`timescale 1ns / 1ps
`include "lifo_stack_with_min_max_macros.svh"
module lifo_stack_with_min_max (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lmm_pkg::lmm_in_t  in_data,
  output logic            out_strobe,
  output lmm_pkg::lmm_out_t out_data
);

  import lmm_pkg::*;

  localparam int AW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int TW = $clog2(StackDepth + 1);

  fsm_t state_r, state_nxt;
  logic accept;

  logic [TW-1:0] top_r, top_nxt;
  logic          cmd_r;
  logic signed [WordW-1:0] val_r;
  logic signed [WordW-1:0] cur_min_r, cur_min_nxt;
  logic signed [WordW-1:0] cur_max_r, cur_max_nxt;

  logic              strobe_r;
  lmm_out_t          out_r, out_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [TW-1:0]     word_ptr, ext_ptr;
  logic [WordW-1:0]  rd_word;
  lmm_ext_t          rd_ext, wr_ext;

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (accept) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy   = (state_r == FSM_EXEC);
    accept = start && (state_r == FSM_IDLE);
  end

  // read pointers: word at top-1, running min/max at top-2
  assign word_ptr = top_r - TW'(1);
  assign ext_ptr  = top_r - TW'(2);

  lmm_ram #(.W(WordW), .DEPTH(StackDepth)) u_word_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_r),
    .raddr (word_ptr[AW-1:0]),
    .rdata (rd_word)
  );

  lmm_ram #(.W(2 * WordW), .DEPTH(StackDepth)) u_ext_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ext),
    .raddr (ext_ptr[AW-1:0]),
    .rdata (rd_ext)
  );

  // execute: combine read data, update top
  always_comb begin
    logic [StatW-1:0]        stat;
    logic signed [WordW-1:0] popped;
    stat        = ST_OK;
    popped      = '0;
    top_nxt     = top_r;
    cur_min_nxt = cur_min_r;
    cur_max_nxt = cur_max_r;
    we          = 1'b0;
    waddr       = top_r[AW-1:0];
    wr_ext.min_val = val_r;
    wr_ext.max_val = val_r;
    if (state_r == FSM_EXEC) begin
      if (cmd_r == CMD_PUSH) begin
        if (top_r == TW'(StackDepth)) begin
          stat = ST_FULL;
        end else begin
          if (top_r != '0) begin
            if (!(val_r < cur_min_r)) wr_ext.min_val = cur_min_r;
            if (!(cur_max_r < val_r)) wr_ext.max_val = cur_max_r;
          end
          we          = 1'b1;
          top_nxt     = top_r + TW'(1);
          cur_min_nxt = wr_ext.min_val;
          cur_max_nxt = wr_ext.max_val;
        end
      end else begin
        if (top_r == '0) begin
          stat = ST_EMPTY;
        end else begin
          popped      = rd_word;
          top_nxt     = top_r - TW'(1);
          cur_min_nxt = rd_ext.min_val;
          cur_max_nxt = rd_ext.max_val;
        end
      end
    end
    out_nxt.popped_value   = popped;
    out_nxt.status         = stat;
    out_nxt.depth          = DepthW'(top_nxt);
    out_nxt.stack_empty    = (top_nxt == '0);
    out_nxt.least_value    = (top_nxt == '0) ? '0 : cur_min_nxt;
    out_nxt.greatest_value = (top_nxt == '0) ? '0 : cur_max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_IDLE;
      top_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      strobe_r <= (state_r == FSM_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      val_r <= in_data.value;
    end
    cur_min_r <= cur_min_nxt;
    cur_max_r <= cur_max_nxt;
    out_r     <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  `LMM_ASSERT_NEXT(a_take_goes_busy, accept, busy, "accepted command did not start execution")
  `LMM_ASSERT_NEXT(a_exec_one_cycle, busy, !busy && out_strobe, "execute not followed by strobe")
  `LMM_ASSERT_NOW(a_top_bound, 1'b1, top_r <= TW'(StackDepth), "top pointer beyond depth")
  `LMM_ASSERT_NOW(a_min_le_max, out_strobe && !out_data.stack_empty,
                  out_data.least_value <= out_data.greatest_value, "least above greatest")

endmodule

FILE: verif/lmm_stack_checker.sv
// Checker for the min/max stack: watches command and result transfers, predicts
// each result from its own copy of the stack, and compares field by field.
// Depends on lmm_pkg.
`timescale 1ns / 1ps
module lmm_stack_checker
  import lmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  lmm_in_t  in_data,
  input  logic     out_strobe,
  input  lmm_out_t out_data,
  output int       mismatch_count,
  output int       pending_count,
  output int       result_count,
  output int       full_count,
  output int       empty_count,
  output int       peak_depth
);

  logic signed [WordW-1:0] word_mem [StackDepth];
  logic signed [WordW-1:0] lo_mem   [StackDepth];
  logic signed [WordW-1:0] hi_mem   [StackDepth];
  int       fill = 0;
  lmm_out_t expected_q[$];

  int errors   = 0;
  int pending  = 0;
  int checked  = 0;
  int fulls    = 0;
  int empties  = 0;
  int deepest  = 0;

  assign mismatch_count = errors;
  assign pending_count  = pending;
  assign result_count   = checked;
  assign full_count     = fulls;
  assign empty_count    = empties;
  assign peak_depth     = deepest;

  function automatic lmm_out_t stack_apply(lmm_in_t cmd_in);
    lmm_out_t r;
    logic signed [WordW-1:0] lo;
    logic signed [WordW-1:0] hi;
    r = '0;
    r.status = ST_OK;
    if (cmd_in.command == CMD_PUSH) begin
      if (fill == StackDepth) begin
        r.status = ST_FULL;
        fulls++;
      end else begin
        lo = cmd_in.value;
        hi = cmd_in.value;
        if (fill > 0) begin
          if (lo_mem[fill-1] < lo) lo = lo_mem[fill-1];
          if (hi_mem[fill-1] > hi) hi = hi_mem[fill-1];
        end
        word_mem[fill] = cmd_in.value;
        lo_mem[fill]   = lo;
        hi_mem[fill]   = hi;
        fill++;
        if (fill > deepest) deepest = fill;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
      empties++;
    end else begin
      fill--;
      r.popped_value = word_mem[fill];
    end
    r.depth = fill[DepthW-1:0];
    if (fill == 0) begin
      r.stack_empty = 1'b1;
    end else begin
      r.least_value    = lo_mem[fill-1];
      r.greatest_value = hi_mem[fill-1];
    end
    return r;
  endfunction

  task automatic report(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("MISMATCH %s at result %0d: got %h want %h", what, checked, got, want);
    errors++;
  endtask

  task automatic compare_result(lmm_out_t got, lmm_out_t want);
    if (got.popped_value !== want.popped_value)
      report("popped_value", got.popped_value, want.popped_value);
    if (got.status !== want.status)
      report("status", WordW'(got.status), WordW'(want.status));
    if (got.depth !== want.depth)
      report("depth", WordW'(got.depth), WordW'(want.depth));
    if (got.least_value !== want.least_value)
      report("least_value", got.least_value, want.least_value);
    if (got.greatest_value !== want.greatest_value)
      report("greatest_value", got.greatest_value, want.greatest_value);
    if (got.stack_empty !== want.stack_empty)
      report("stack_empty", WordW'(got.stack_empty), WordW'(want.stack_empty));
  endtask

  always @(posedge clk) begin
    lmm_out_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (expected_q.size() == 0) begin
          report("result with nothing expected", out_data.popped_value, '0);
        end else begin
          want = expected_q.pop_front();
          compare_result(out_data, want);
          checked++;
        end
      end
      if (start && busy === 1'b0) expected_q.push_back(stack_apply(in_data));
      pending = expected_q.size();
    end
  end

endmodule

FILE: verif/lifo_stack_with_min_max_tb.sv
// Testbench top for the min/max stack: drives push and pop commands with random
// gaps, and takes the verdict from lmm_stack_checker.
// Depends on lmm_pkg, lmm_stack_checker and lifo_stack_with_min_max.
`timescale 1ns / 1ps
module lifo_stack_with_min_max_tb;
  import lmm_pkg::*;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  lmm_in_t  in_data = '0;
  logic     busy;
  logic     out_strobe;
  lmm_out_t out_data;

  int mismatch_count;
  int pending_count;
  int result_count;
  int full_count;
  int empty_count;
  int peak_depth;

  int sent    = 0;
  bit gaps_on = 1'b1;

  always #5 clk = ~clk;

  lifo_stack_with_min_max u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  lmm_stack_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .result_count   (result_count),
    .full_count     (full_count),
    .empty_count    (empty_count),
    .peak_depth     (peak_depth)
  );

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 6)) - 32'd3;
      3:       return {WordW{1'($urandom_range(0, 1))}};
      default: return $urandom;
    endcase
  endfunction

  task automatic send(cmd_t op, logic [WordW-1:0] word);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{command: op, value: word};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    int      wait_cycles;
    int      burst_len;
    int      push_pct;
    cmd_t    op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_POP, 32'h0000_0000);
    send(CMD_PUSH, 32'h7fff_ffff);
    send(CMD_PUSH, 32'h8000_0000);
    send(CMD_PUSH, 32'h0000_0000);
    send(CMD_PUSH, 32'hffff_ffff);
    send(CMD_PUSH, 32'h8000_0000);
    send(CMD_PUSH, 32'h7fff_ffff);
    send(CMD_PUSH, 32'h0000_0005);
    repeat (7) send(CMD_POP, 32'hffff_ffff);
    send(CMD_POP, 32'hdead_beef);
    send(CMD_PUSH, 32'hffff_ffff);
    send(CMD_PUSH, 32'h0000_0001);
    send(CMD_POP, 32'hdead_beef);
    send(CMD_POP, 32'h0000_0000);

    // fill past the top, then drain past the bottom
    repeat (262) send(CMD_PUSH, rand_word());
    gaps_on = 1'b0;
    repeat (40) send(CMD_POP, rand_word());
    gaps_on = 1'b1;
    repeat (222) send(CMD_POP, rand_word());

    while (sent < 920) begin
      burst_len = $urandom_range(10, 80);
      gaps_on   = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (burst_len) begin
        op = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        send(op, rand_word());
      end
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);

    $display("covered %0d commands and %0d results, peak depth %0d", sent, result_count,
             peak_depth);
    $display("including %0d pushes onto a full stack and %0d pops of an empty one",
             full_count, empty_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout waiting for transfers");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
